@@ rtl/core/stok_pkg.sv @@
// ----------------------------------------------------------------------------
// Source tokenizer package
// Shared types, token codes, keyword tables and byte classifiers.
// ----------------------------------------------------------------------------
package stok_pkg;

   localparam int POSITION_BITS_DEF = 20;
   localparam int FIELD_POS_BITS    = 20;
   localparam int MAX_RSP           = 3;
   localparam int RSP_DEPTH         = 8;
   localparam int KW_COUNT          = 9;

   localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

   // token kinds
   localparam logic [4:0] KIND_END     = 5'd0;
   localparam logic [4:0] KIND_WORD    = 5'd1;
   localparam logic [4:0] KIND_NUMBER  = 5'd2;
   localparam logic [4:0] KIND_CHAR    = 5'd3;
   localparam logic [4:0] KIND_KW_BASE = 5'd4;
   localparam logic [4:0] KIND_PLUS    = 5'd13;
   localparam logic [4:0] KIND_MINUS   = 5'd14;
   localparam logic [4:0] KIND_SEMI    = 5'd15;
   localparam logic [4:0] KIND_STAR    = 5'd16;
   localparam logic [4:0] KIND_SLASH   = 5'd17;
   localparam logic [4:0] KIND_LPAREN  = 5'd18;
   localparam logic [4:0] KIND_RPAREN  = 5'd19;
   localparam logic [4:0] KIND_ASSIGN  = 5'd20;
   localparam logic [4:0] KIND_COMMA   = 5'd21;
   localparam logic [4:0] KIND_LBRACE  = 5'd22;
   localparam logic [4:0] KIND_RBRACE  = 5'd23;
   localparam logic [4:0] KIND_LESS    = 5'd24;
   localparam logic [4:0] KIND_GREATER = 5'd25;
   localparam logic [4:0] KIND_LE      = 5'd26;
   localparam logic [4:0] KIND_GE      = 5'd27;
   localparam logic [4:0] KIND_EQ      = 5'd28;
   localparam logic [4:0] KIND_NONE    = 5'd0;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
   localparam logic [1:0] ERR_BAD_CHAR   = 2'd2;

   // characters with a role of their own
   localparam logic [7:0] CH_QUOTE      = 8'h27;
   localparam logic [7:0] CH_LT         = 8'h3C;
   localparam logic [7:0] CH_GT         = 8'h3E;
   localparam logic [7:0] CH_EQ         = 8'h3D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   // keyword text, right justified: last character in the low byte
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      "print", "int", "char", "function", "return", "if", "bool", "true", "false"
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd5, 4'd3, 4'd4, 4'd8, 4'd6, 4'd2, 4'd4, 4'd4, 4'd5
   };

   typedef struct packed {
      logic [7:0] text_byte;
      logic       byte_present;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [30:0] number_value;
      logic [7:0]  char_value;
      logic [19:0] word_start;
      logic [19:0] word_length;
      logic [1:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        count;
      rsp_type [2:0]     entry;
   } push_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   endfunction

   // character p of keyword k, valid for p below the keyword length
   function automatic logic [7:0] kw_byte(input int k, input logic [2:0] p);
      logic [3:0]  sh;
      logic [63:0] text;
      sh   = KW_LEN[k] - {1'b0, p} - 4'd1;
      text = KW_TEXT[k] >> {sh, 3'b000};
      return text[7:0];
   endfunction

   function automatic logic [4:0] op_kind(input logic [7:0] b);
      logic [4:0] k;
      unique case (b)
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h3B:   k = KIND_SEMI;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         CH_EQ:   k = KIND_ASSIGN;
         8'h2C:   k = KIND_COMMA;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         CH_LT:   k = KIND_LESS;
         CH_GT:   k = KIND_GREATER;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic rsp_type mk_rsp(input logic [4:0] kind, input logic [30:0] num,
                                      input logic [7:0] ch, input logic [19:0] ws,
                                      input logic [19:0] wl, input logic [1:0] err,
                                      input logic last);
      rsp_type r;
      r.token_kind   = kind;
      r.number_value = num;
      r.char_value   = ch;
      r.word_start   = ws;
      r.word_length  = wl;
      r.error_code   = err;
      r.last_of_run  = last;
      return r;
   endfunction

endpackage

@@ rtl/core/stok_if.sv @@
// ----------------------------------------------------------------------------
// Source tokenizer channels
// Valid/ready channels for text items and result tokens.
// ----------------------------------------------------------------------------
interface stok_req_if;
   logic              valid;
   logic              ready;
   stok_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface stok_rsp_if;
   logic              valid;
   logic              ready;
   stok_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/stok_scan.sv @@
// ----------------------------------------------------------------------------
// Tokenizer scan stage
// Holds the scanner state and turns one text item into up to three results.
// ----------------------------------------------------------------------------
module stok_scan #(
   parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  stok_pkg::req_type  req,
   output stok_pkg::push_type push
);
   import stok_pkg::*;

   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_WORD  = 3'd1;
   localparam logic [2:0] MODE_NUM   = 3'd2;
   localparam logic [2:0] MODE_QUOTE = 3'd3;
   localparam logic [2:0] MODE_CHAR  = 3'd4;
   localparam logic [2:0] MODE_OP    = 3'd5;

   localparam logic [KW_COUNT-1:0] ALL_KW = '1;

   logic [2:0]               mode_ff,  mode_in;
   logic [KW_COUNT-1:0]      cand_ff,  cand_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic [POSITION_BITS-1:0] len_ff,   len_in;
   logic [30:0]              acc_ff,   acc_in;
   logic [7:0]               held_ff,  held_in;
   logic [POSITION_BITS-1:0] pos_ff,   pos_in;
   logic                     drop_ff,  drop_in;

   logic       fall;
   logic [1:0] err;
   logic [7:0] b;
   logic [34:0] prod;
   logic [3:0] slot_v;
   rsp_type    slot_r [4];
   logic [1:0] n;

   // shrink the keyword mask by one more character
   function automatic logic [KW_COUNT-1:0] cand_step(input logic [KW_COUNT-1:0] cand,
                                                    input logic [POSITION_BITS-1:0] len,
                                                    input logic [7:0] ch);
      logic [KW_COUNT-1:0] keep;
      for (int k = 0; k < KW_COUNT; k++) begin
         keep[k] = cand[k] && (len < POSITION_BITS'(KW_LEN[k]))
                   && (kw_byte(k, len[2:0]) == ch);
      end
      return keep;
   endfunction

   function automatic rsp_type word_rsp(input logic [KW_COUNT-1:0] cand,
                                        input logic [POSITION_BITS-1:0] len,
                                        input logic [POSITION_BITS-1:0] start);
      logic       found;
      logic [4:0] kind;
      found = 1'b0;
      kind  = KIND_WORD;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!found && cand[k] && len == POSITION_BITS'(KW_LEN[k])) begin
            kind  = KIND_KW_BASE + 5'(k);
            found = 1'b1;
         end
      end
      if (found) begin
         return mk_rsp(kind, '0, '0, '0, '0, ERR_NONE, 1'b0);
      end
      return mk_rsp(KIND_WORD, '0, '0, FIELD_POS_BITS'(start), FIELD_POS_BITS'(len),
                    ERR_NONE, 1'b0);
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      cand_in  = cand_ff;
      start_in = start_ff;
      len_in   = len_ff;
      acc_in   = acc_ff;
      held_in  = held_ff;
      pos_in   = pos_ff;
      drop_in  = drop_ff;
      fall     = 1'b0;
      err      = ERR_NONE;
      b        = req.text_byte;
      slot_v   = '0;
      for (int i = 0; i < 4; i++) begin
         slot_r[i] = '0;
      end
      prod = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {31'b0, b[3:0]};

      if (accept) begin
         if (drop_ff) begin
            if (req.end_of_text) begin
               drop_in = 1'b0;
            end
         end else begin
            if (req.byte_present) begin
               pos_in = pos_ff + POSITION_BITS'(1);
               // close or extend the pending token
               unique case (mode_ff)
                  MODE_WORD: begin
                     if (is_alpha(b) || is_digit(b) || b == CH_UNDERSCORE) begin
                        cand_in = cand_step(cand_ff, len_ff, b);
                        len_in  = (&len_ff) ? len_ff : len_ff + POSITION_BITS'(1);
                     end else begin
                        slot_v[0] = 1'b1;
                        slot_r[0] = word_rsp(cand_ff, len_ff, start_ff);
                        fall      = 1'b1;
                     end
                  end
                  MODE_NUM: begin
                     if (is_digit(b)) begin
                        acc_in = (prod > {4'b0, NUM_MAX}) ? NUM_MAX : prod[30:0];
                     end else begin
                        slot_v[0] = 1'b1;
                        slot_r[0] = mk_rsp(KIND_NUMBER, acc_ff, '0, '0, '0, ERR_NONE, 1'b0);
                        fall      = 1'b1;
                     end
                  end
                  MODE_QUOTE: begin
                     held_in = b;
                     mode_in = MODE_CHAR;
                  end
                  MODE_CHAR: begin
                     if (b != CH_QUOTE) begin
                        err = ERR_BAD_CHAR;
                     end else begin
                        slot_v[0] = 1'b1;
                        slot_r[0] = mk_rsp(KIND_CHAR, '0, held_ff, '0, '0, ERR_NONE, 1'b0);
                        mode_in   = MODE_IDLE;
                        held_in   = '0;
                     end
                  end
                  MODE_OP: begin
                     slot_v[0] = 1'b1;
                     if (b == CH_EQ) begin
                        slot_r[0] = mk_rsp((held_ff == CH_LT) ? KIND_LE :
                                           (held_ff == CH_GT) ? KIND_GE : KIND_EQ,
                                           '0, '0, '0, '0, ERR_NONE, 1'b0);
                        mode_in   = MODE_IDLE;
                        held_in   = '0;
                     end else begin
                        slot_r[0] = mk_rsp(op_kind(held_ff), '0, '0, '0, '0, ERR_NONE, 1'b0);
                        fall      = 1'b1;
                     end
                  end
                  default: fall = 1'b1;
               endcase

               // start a new token from this byte
               if (fall) begin
                  mode_in = MODE_IDLE;
                  held_in = '0;
                  priority if (is_space(b)) begin
                     mode_in = MODE_IDLE;
                  end else if (is_alpha(b) || b == CH_UNDERSCORE) begin
                     mode_in  = MODE_WORD;
                     cand_in  = cand_step(ALL_KW, '0, b);
                     start_in = pos_ff;
                     len_in   = POSITION_BITS'(1);
                  end else if (is_digit(b)) begin
                     mode_in = MODE_NUM;
                     acc_in  = {27'b0, b[3:0]};
                  end else if (b == CH_QUOTE) begin
                     mode_in = MODE_QUOTE;
                  end else if (b == CH_LT || b == CH_GT || b == CH_EQ) begin
                     mode_in = MODE_OP;
                     held_in = b;
                  end else if (op_kind(b) != KIND_NONE) begin
                     slot_v[1] = 1'b1;
                     slot_r[1] = mk_rsp(op_kind(b), '0, '0, '0, '0, ERR_NONE, 1'b0);
                  end else begin
                     err = ERR_UNEXPECTED;
                  end
               end
            end

            // flush the pending token at the end of the text
            if (err == ERR_NONE && req.end_of_text) begin
               unique case (mode_in)
                  MODE_WORD: begin
                     slot_v[2] = 1'b1;
                     slot_r[2] = word_rsp(cand_in, len_in, start_in);
                  end
                  MODE_NUM: begin
                     slot_v[2] = 1'b1;
                     slot_r[2] = mk_rsp(KIND_NUMBER, acc_in, '0, '0, '0, ERR_NONE, 1'b0);
                  end
                  MODE_QUOTE, MODE_CHAR: err = ERR_BAD_CHAR;
                  MODE_OP: begin
                     slot_v[2] = 1'b1;
                     slot_r[2] = mk_rsp(op_kind(held_in), '0, '0, '0, '0, ERR_NONE, 1'b0);
                  end
                  default: slot_v[2] = 1'b0;
               endcase
               if (err == ERR_NONE) begin
                  slot_v[3] = 1'b1;
                  slot_r[3] = mk_rsp(KIND_END, '0, '0, '0, '0, ERR_NONE, 1'b1);
               end
            end

            if (err != ERR_NONE) begin
               slot_v[3] = 1'b1;
               slot_r[3] = mk_rsp(KIND_END, '0, '0, '0, '0, err, 1'b1);
               drop_in   = !req.end_of_text;
            end
            if (err != ERR_NONE || req.end_of_text) begin
               mode_in  = MODE_IDLE;
               cand_in  = ALL_KW;
               start_in = '0;
               len_in   = '0;
               acc_in   = '0;
               held_in  = '0;
               pos_in   = '0;
            end
         end
      end

      // pack the results in order, dropping any beyond the third
      n    = 2'd0;
      push = '0;
      for (int i = 0; i < 4; i++) begin
         if (slot_v[i] && n < 2'd3) begin
            push.entry[n] = slot_r[i];
            n = n + 2'd1;
         end
      end
      push.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         cand_ff  <= ALL_KW;
         start_ff <= '0;
         len_ff   <= '0;
         acc_ff   <= '0;
         held_ff  <= '0;
         pos_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         cand_ff  <= cand_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         acc_ff   <= acc_in;
         held_ff  <= held_in;
         pos_ff   <= pos_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

@@ rtl/core/stok_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Takes up to three results per cycle and hands them out one per transfer.
// ----------------------------------------------------------------------------
module stok_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  stok_pkg::push_type push,
   output logic               space_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output stok_pkg::rsp_type  rsp_data
);
   import stok_pkg::*;

   localparam int AW = $clog2(RSP_DEPTH);
   localparam int CW = AW + 1;

   rsp_type         mem_ff [RSP_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff,  count_in;
   logic            pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   // leave room for the largest burst of one item
   assign space_ok  = count_ff <= CW'(RSP_DEPTH - MAX_RSP);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(push.count);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RSP; i++) begin
         if (2'(i) < push.count) begin
            mem_ff[wr_ptr_ff + AW'(i)] <= push.entry[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/source_tokenizer_core.sv @@
// Results: an item's results are written to the result queue on its transfer.
// Throughput: one text item per cycle while not held off; each item gives zero
//   to three results, leaving the eight-entry result queue one per ready cycle.
// Input is held off while the queue has fewer than three free entries.
// Reset: synchronous, active high; clears the scanner state and the queue.
// ----------------------------------------------------------------------------
// Source tokenizer top level
// Lexical analyzer: text bytes in, tokens out over valid/ready channels.
// ----------------------------------------------------------------------------
module source_tokenizer_core #(
   parameter int POSITION_BITS = stok_pkg::POSITION_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   stok_req_if.sink   req_chan,
   stok_rsp_if.source rsp_chan
);
   import stok_pkg::*;

   push_type push;
   logic     space_ok;
   logic     accept;

   assign req_chan.ready = space_ok;
   assign accept         = req_chan.valid && space_ok;

   stok_scan #(
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_chan.payload),
      .push   (push)
   );

   stok_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_chan.payload)
   );

endmodule

@@ bench/stok_token_checker.sv @@
// ----------------------------------------------------------------------------
// Source tokenizer token checker
// Watches both channels of the tokenizer, predicts the tokens of every text
// item it sees go in, and compares each token that comes out, field by field.
// ----------------------------------------------------------------------------
module stok_token_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  stok_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  stok_pkg::rsp_type rsp_token,
   output int unsigned       mismatches,
   output int unsigned       outstanding,
   output int unsigned       tokens_checked
);
   import stok_pkg::*;

   localparam int POS_BITS = POSITION_BITS_DEF;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_QUOTE, SCAN_CHAR, SCAN_OP
   } scan_mode_type;

   string keyword_word [KW_COUNT] = '{
      "print", "int", "char", "function", "return", "if", "bool", "true", "false"
   };

   // scanner state
   scan_mode_type         scan;
   logic [KW_COUNT-1:0]   kw_alive;
   logic [POS_BITS-1:0]   word_begin;
   logic [POS_BITS-1:0]   word_size;
   logic [POS_BITS-1:0]   text_pos;
   logic [30:0]           number_sum;
   logic [7:0]            held_char;
   logic                  dropping;

   rsp_type               expected_tokens [$];
   int                    item_tokens;

   function automatic logic blank_char(input logic [7:0] b);
      return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic digit_char(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic letter_char(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic [4:0] op_token(input logic [7:0] b);
      case (b)
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         ";":     return KIND_SEMI;
         "*":     return KIND_STAR;
         "/":     return KIND_SLASH;
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         CH_EQ:   return KIND_ASSIGN;
         ",":     return KIND_COMMA;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         CH_LT:   return KIND_LESS;
         CH_GT:   return KIND_GREATER;
         default: return KIND_NONE;
      endcase
   endfunction

   task automatic push_expected(input logic [4:0] kind, input logic [30:0] num,
                                input logic [7:0] ch, input logic [POS_BITS-1:0] ws,
                                input logic [POS_BITS-1:0] wl, input logic [1:0] err,
                                input logic last);
      rsp_type t;
      if (item_tokens < MAX_RSP) begin
         t.token_kind   = kind;
         t.number_value = num;
         t.char_value   = ch;
         t.word_start   = ws[19:0];
         t.word_length  = wl[19:0];
         t.error_code   = err;
         t.last_of_run  = last;
         expected_tokens.push_back(t);
         item_tokens++;
      end
   endtask

   task automatic restart_scan();
      scan       = SCAN_IDLE;
      kw_alive   = '1;
      word_begin = '0;
      word_size  = '0;
      number_sum = '0;
      held_char  = '0;
      text_pos   = '0;
   endtask

   // drop every keyword that cannot match this byte at this place
   task automatic grow_word(input logic [7:0] b);
      for (int k = 0; k < KW_COUNT; k++)
         if (word_size >= keyword_word[k].len() || keyword_word[k][word_size] != b)
            kw_alive[k] = 1'b0;
      if (word_size != '1)
         word_size++;
   endtask

   task automatic close_word();
      for (int k = 0; k < KW_COUNT; k++)
         if (kw_alive[k] && keyword_word[k].len() == word_size) begin
            push_expected(KIND_KW_BASE + 5'(k), '0, '0, '0, '0, ERR_NONE, 1'b0);
            return;
         end
      push_expected(KIND_WORD, '0, '0, word_begin, word_size, ERR_NONE, 1'b0);
   endtask

   task automatic scan_byte(input logic [7:0] b, output logic [1:0] err);
      logic [POS_BITS-1:0] here;
      logic [34:0]         wide;
      logic                taken;
      here     = text_pos;
      text_pos = text_pos + 1'b1;
      err      = ERR_NONE;
      taken    = 1'b0;
      case (scan)
         SCAN_WORD: begin
            if (letter_char(b) || digit_char(b) || b == CH_UNDERSCORE) begin
               grow_word(b);
               taken = 1'b1;
            end else begin
               close_word();
            end
         end
         SCAN_NUM: begin
            if (digit_char(b)) begin
               wide       = 35'(number_sum) * 35'd10 + 35'(b) - 35'h30;
               number_sum = (wide > 35'(NUM_MAX)) ? NUM_MAX : wide[30:0];
               taken      = 1'b1;
            end else begin
               push_expected(KIND_NUMBER, number_sum, '0, '0, '0, ERR_NONE, 1'b0);
            end
         end
         SCAN_QUOTE: begin
            held_char = b;
            scan      = SCAN_CHAR;
            taken     = 1'b1;
         end
         SCAN_CHAR: begin
            taken = 1'b1;
            if (b != CH_QUOTE) begin
               err = ERR_BAD_CHAR;
            end else begin
               push_expected(KIND_CHAR, '0, held_char, '0, '0, ERR_NONE, 1'b0);
               scan      = SCAN_IDLE;
               held_char = '0;
            end
         end
         SCAN_OP: begin
            if (b == CH_EQ) begin
               if (held_char == CH_LT)
                  push_expected(KIND_LE, '0, '0, '0, '0, ERR_NONE, 1'b0);
               else if (held_char == CH_GT)
                  push_expected(KIND_GE, '0, '0, '0, '0, ERR_NONE, 1'b0);
               else
                  push_expected(KIND_EQ, '0, '0, '0, '0, ERR_NONE, 1'b0);
               scan      = SCAN_IDLE;
               held_char = '0;
               taken     = 1'b1;
            end else begin
               push_expected(op_token(held_char), '0, '0, '0, '0, ERR_NONE, 1'b0);
            end
         end
         default: ;
      endcase

      // byte not absorbed by the pending token: start a new one from it
      if (!taken) begin
         scan      = SCAN_IDLE;
         held_char = '0;
         if (blank_char(b)) begin
         end else if (letter_char(b) || b == CH_UNDERSCORE) begin
            scan       = SCAN_WORD;
            kw_alive   = '1;
            word_begin = here;
            word_size  = '0;
            grow_word(b);
         end else if (digit_char(b)) begin
            scan       = SCAN_NUM;
            number_sum = 31'(b - 8'h30);
         end else if (b == CH_QUOTE) begin
            scan = SCAN_QUOTE;
         end else if (b == CH_LT || b == CH_GT || b == CH_EQ) begin
            scan      = SCAN_OP;
            held_char = b;
         end else if (op_token(b) != KIND_NONE) begin
            push_expected(op_token(b), '0, '0, '0, '0, ERR_NONE, 1'b0);
         end else begin
            err = ERR_UNEXPECTED;
         end
      end
   endtask

   task automatic predict_item(input req_type it);
      logic [1:0] err;
      item_tokens = 0;
      err         = ERR_NONE;
      if (dropping) begin
         if (it.end_of_text) begin
            restart_scan();
            dropping = 1'b0;
         end
      end else begin
         if (it.byte_present)
            scan_byte(it.text_byte, err);
         if (err == ERR_NONE && it.end_of_text) begin
            case (scan)
               SCAN_WORD:  close_word();
               SCAN_NUM:   push_expected(KIND_NUMBER, number_sum, '0, '0, '0, ERR_NONE, 1'b0);
               SCAN_QUOTE,
               SCAN_CHAR:  err = ERR_BAD_CHAR;
               SCAN_OP:    push_expected(op_token(held_char), '0, '0, '0, '0, ERR_NONE, 1'b0);
               default: ;
            endcase
            if (err == ERR_NONE)
               push_expected(KIND_END, '0, '0, '0, '0, ERR_NONE, 1'b1);
         end
         if (err != ERR_NONE) begin
            push_expected(KIND_NONE, '0, '0, '0, '0, err, 1'b1);
            restart_scan();
            dropping = !it.end_of_text;
         end else if (it.end_of_text) begin
            restart_scan();
         end
      end
   endtask

   task automatic check_token(input rsp_type want, input rsp_type got);
      if (got.token_kind !== want.token_kind) begin
         $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
         mismatches++;
      end
      if (got.number_value !== want.number_value) begin
         $error("number_value: expected %0d, got %0d", want.number_value, got.number_value);
         mismatches++;
      end
      if (got.char_value !== want.char_value) begin
         $error("char_value: expected 0x%02h, got 0x%02h", want.char_value, got.char_value);
         mismatches++;
      end
      if (got.word_start !== want.word_start) begin
         $error("word_start: expected %0d, got %0d", want.word_start, got.word_start);
         mismatches++;
      end
      if (got.word_length !== want.word_length) begin
         $error("word_length: expected %0d, got %0d", want.word_length, got.word_length);
         mismatches++;
      end
      if (got.error_code !== want.error_code) begin
         $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
         mismatches++;
      end
      if (got.last_of_run !== want.last_of_run) begin
         $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
         mismatches++;
      end
   endtask

   initial begin
      mismatches     = 0;
      outstanding    = 0;
      tokens_checked = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         restart_scan();
         dropping = 1'b0;
         expected_tokens.delete();
      end else begin
         // predict first so a same-edge token would still find its expectation
         if (req_valid && req_ready)
            predict_item(req_item);
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("token_kind: expected no token, got %0d", rsp_token.token_kind);
               mismatches++;
            end else begin
               check_token(expected_tokens.pop_front(), rsp_token);
               tokens_checked++;
            end
         end
      end
      outstanding = expected_tokens.size();
   end

endmodule

@@ bench/tb_source_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// Source tokenizer testbench
// Feeds directed corner cases and then random source texts, mostly well
// formed with a few broken ones, under random idling and one long output
// stall; the token checker predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_source_tokenizer_core;
   import stok_pkg::*;

   localparam int ITEM_GOAL      = 230;
   localparam int CALM_ITEMS     = 40;
   localparam int LONG_STALL     = 80;
   localparam int SETTLE_CYCLES  = 10;
   localparam int CYCLE_LIMIT    = 200000;

   localparam string WORD_BYTES =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
   localparam string LEAD_BYTES =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   localparam string DIGITS     = "0123456789";
   localparam string OP_BYTES   = "+-;*/()=,{}<>";

   localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   string keyword_text [KW_COUNT] = '{
      "print", "int", "char", "function", "return", "if", "bool", "true", "false"
   };
   string pair_ops [3]    = '{"<=", ">=", "=="};
   string big_numbers [3] = '{"2147483647", "2147483648", "99999999999999"};

   logic        clock = 1'b0;
   logic        reset;
   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned tokens_checked;
   int unsigned cycle_count = 0;

   int          items_sent = 0;
   int          texts_sent = 0;
   int          idle_pct   = 0;
   logic        calm       = 1'b0;
   logic        long_stall_wanted = 1'b0;
   req_type     text_items [$];

   stok_req_if req_chan ();
   stok_rsp_if rsp_chan ();

   source_tokenizer_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   stok_token_checker CHECK (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_item       (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_token      (rsp_chan.payload),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .tokens_checked (tokens_checked)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** source_tokenizer_core: FAILED **");
         $finish;
      end
   end

   // offer one item and hold it until the transfer; keep offering during the long stall
   task automatic send_item(input logic [7:0] b, input logic present, input logic eot);
      req_type it;
      it.text_byte    = b;
      it.byte_present = present;
      it.end_of_text  = eot;
      if (items_sent + CALM_ITEMS >= ITEM_GOAL)
         calm = 1'b1;
      if (!calm && !long_stall_wanted && idle_pct != 0
          && $urandom_range(1, 100) <= idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= it;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic append_byte(input logic [7:0] b);
      req_type it;
      it.text_byte    = b;
      it.byte_present = 1'b1;
      it.end_of_text  = 1'b0;
      text_items.push_back(it);
   endtask

   task automatic append_empty(input logic eot);
      req_type it;
      it.text_byte    = 8'($urandom);
      it.byte_present = 1'b0;
      it.end_of_text  = eot;
      text_items.push_back(it);
   endtask

   task automatic append_text(input string s);
      for (int i = 0; i < s.len(); i++)
         append_byte(s[i]);
   endtask

   task automatic append_lexeme();
      string w;
      int    cut;
      case ($urandom_range(0, 9))
         0, 1: append_text(keyword_text[$urandom_range(0, KW_COUNT - 1)]);
         2: begin
            // keyword prefix, sometimes extended by one word byte: tests the candidate mask
            w   = keyword_text[$urandom_range(0, KW_COUNT - 1)];
            cut = $urandom_range(1, w.len());
            for (int i = 0; i < cut; i++)
               append_byte(w[i]);
            if ($urandom_range(0, 1))
               append_byte(WORD_BYTES[$urandom_range(0, WORD_BYTES.len() - 1)]);
         end
         3: begin
            append_byte(LEAD_BYTES[$urandom_range(0, LEAD_BYTES.len() - 1)]);
            repeat ($urandom_range(0, 11))
               append_byte(WORD_BYTES[$urandom_range(0, WORD_BYTES.len() - 1)]);
         end
         4: repeat ($urandom_range(1, 10)) append_byte(DIGITS[$urandom_range(0, 9)]);
         5: begin
            append_byte(CH_QUOTE);
            append_byte(8'($urandom_range(0, 255)));
            append_byte(CH_QUOTE);
         end
         6, 7: append_byte(OP_BYTES[$urandom_range(0, OP_BYTES.len() - 1)]);
         8: append_text(pair_ops[$urandom_range(0, 2)]);
         default: append_text(big_numbers[$urandom_range(0, 2)]);
      endcase
   endtask

   task automatic build_text();
      run_setup:
      text_items.delete();
      repeat ($urandom_range(2, 9)) begin
         append_lexeme();
         if ($urandom_range(0, 4) != 0)
            repeat ($urandom_range(1, 2)) append_byte(BLANKS[$urandom_range(0, 5)]);
         if ($urandom_range(0, 29) == 0)
            append_empty(1'b0);
      end
      // break a few texts at their tail so little gets dropped
      case ($urandom_range(0, 19))
         0: append_byte(8'($urandom_range(0, 255)));
         1: append_byte(CH_QUOTE);
         2: begin
            append_byte(CH_QUOTE);
            append_byte(8'($urandom_range(0, 255)));
            append_byte(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0 || text_items.size() == 0)
         append_empty(1'b1);
      else
         text_items[text_items.size() - 1].end_of_text = 1'b1;
   endtask

   // result side: random stalls, one long hold-off on request, none when calm
   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_stall_wanted) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            long_stall_wanted = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      reset            <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // unexpected byte, a dropped byte, then restart on the final item
      send_item(8'h00, 1'b1, 1'b0);
      send_item("x",   1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b1);
      // empty text, and an error on the final item itself
      send_item(8'h5A, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      // two-byte operators and a one-byte fallback
      send_item(CH_LT, 1'b1, 1'b0);
      send_item(CH_EQ, 1'b1, 1'b0);
      send_item(CH_GT, 1'b1, 1'b0);
      send_item(8'h20, 1'b1, 1'b0);
      send_item(CH_EQ, 1'b1, 1'b0);
      send_item(CH_EQ, 1'b1, 1'b0);
      // a char literal holding the top byte, then a quote opening another
      send_item(CH_QUOTE, 1'b1, 1'b0);
      send_item(8'hFF,    1'b1, 1'b0);
      send_item(CH_QUOTE, 1'b1, 1'b0);
      send_item(CH_QUOTE, 1'b1, 1'b0);
      send_item(CH_QUOTE, 1'b1, 1'b0);
      // wrong closing byte, then drop until the final item
      send_item("q", 1'b1, 1'b0);
      send_item("a", 1'b1, 1'b1);
      send_item(8'h00, 1'b0, 1'b0);
      send_item("i", 1'b1, 1'b0);
      send_item("f", 1'b1, 1'b0);
      send_item("(", 1'b1, 1'b0);
      send_item("7", 1'b1, 1'b0);
      // literal left open at the end of text, then a flushed operator
      send_item(CH_QUOTE, 1'b1, 1'b1);
      send_item(CH_GT,    1'b1, 1'b1);
      texts_sent = 6;

      long_stall_wanted = 1'b1;
      while (items_sent < ITEM_GOAL) begin
         build_text();
         case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            default: idle_pct = 40;
         endcase
         foreach (text_items[i])
            send_item(text_items[i].text_byte, text_items[i].byte_present,
                      text_items[i].end_of_text);
         texts_sent++;
      end
      req_chan.valid <= 1'b0;

      // let the checker see the last transfer before looking at its backlog
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d text items in %0d texts; %0d tokens checked.",
               items_sent, texts_sent, tokens_checked);
      $display("Included keywords, saturating numbers, char literals, error recovery, "
               , "and a long result stall.");
      if (mismatches == 0 && outstanding == 0)
         $display("** source_tokenizer_core: PASSED **");
      else
         $display("** source_tokenizer_core: FAILED **");
      $finish;
   end

endmodule
